### src/ogg_sbs_pkg.sv
// Shared constants and types for the Ogg stream boundary scanner.
`default_nettype none

package ogg_sbs_pkg;

	localparam int unsigned WIN_LEN         = 27;
	localparam int unsigned RESULT_W        = 40;
	localparam int unsigned MIN_KIB_W       = 16;
	localparam int unsigned KIB_SHIFT       = 10;
	localparam int unsigned MIN_BYTES_W     = MIN_KIB_W + KIB_SHIFT;
	localparam int unsigned DEF_OFFSET_BITS = 40;

	// capture pattern "OggS"
	localparam logic [7:0] SYNC_O = 8'h4F;
	localparam logic [7:0] SYNC_G = 8'h67;
	localparam logic [7:0] SYNC_S = 8'h53;

	// header type codes
	localparam logic [7:0] TYPE_BOS      = 8'h02;
	localparam logic [7:0] TYPE_EOS      = 8'h04;
	localparam logic [7:0] TYPE_EOS_CONT = 8'h05;

	// result kinds
	localparam logic KIND_STREAM = 1'b0;
	localparam logic KIND_TRUNC  = 1'b1;

	typedef struct packed {
		logic       sig_match;  // window opens with the capture pattern
		logic [7:0] hdr_type;   // header type byte of that window
		logic       tail_sync;  // a capital O sits in the last 26 bytes
	} win_info_t;

	typedef struct packed {
		logic                valid;
		logic                kind;
		logic [RESULT_W-1:0] start_ofs;
		logic [RESULT_W-1:0] end_ofs;
	} trk_result_t;

	typedef struct packed {
		logic collecting;
		logic segs_nonzero;
		logic begin_seen;
	} trk_status_t;

endpackage

`default_nettype wire

### src/ogg_sbs_window.sv
// 27-byte sliding header window with capture-pattern and truncation detect.
`default_nettype none

module ogg_sbs_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  logic                  clear,
	input  logic [7:0]            data_byte,
	output ogg_sbs_pkg::win_info_t info
);
	import ogg_sbs_pkg::*;

	logic [7:0] win_q [WIN_LEN];
	logic [7:0] win_n [WIN_LEN];
	logic       tail_sync;

	// window as it stands once the new byte is in
	always_comb begin
		for (int i = 0; i < WIN_LEN - 1; i++) begin
			win_n[i] = win_q[i+1];
		end
		win_n[WIN_LEN-1] = data_byte;
	end

	always_comb begin
		tail_sync = 1'b0;
		for (int i = 1; i < WIN_LEN; i++) begin
			tail_sync = tail_sync | (win_n[i] == SYNC_O);
		end
	end

	assign info.sig_match = (win_n[0] == SYNC_O) && (win_n[1] == SYNC_G) &&
		(win_n[2] == SYNC_G) && (win_n[3] == SYNC_S);
	assign info.hdr_type  = win_n[5];
	assign info.tail_sync = tail_sync;

	// cleared bytes read as zero, so a short container never matches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= 8'h00;
			end
		end else if (shift_en) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= clear ? 8'h00 : win_n[i];
			end
		end
	end

endmodule

`default_nettype wire

### src/ogg_sbs_tracker.sv
// Offset counter, stream start/end tracking and result formation.
`default_nettype none

module ogg_sbs_tracker #(
	parameter int unsigned OFFSET_BITS = ogg_sbs_pkg::DEF_OFFSET_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [7:0]                         data_byte,
	input  logic                               eoc,
	input  logic [ogg_sbs_pkg::MIN_KIB_W-1:0]  min_size_kib,
	input  ogg_sbs_pkg::win_info_t             info,
	output ogg_sbs_pkg::trk_result_t           res,
	output ogg_sbs_pkg::trk_status_t           status
);
	import ogg_sbs_pkg::*;

	localparam int unsigned CMP_W = (OFFSET_BITS > MIN_BYTES_W) ? OFFSET_BITS : MIN_BYTES_W;

	logic [OFFSET_BITS-1:0] ofs_q, ofs_n;
	logic [OFFSET_BITS-1:0] begin_q, begin_n;
	logic [OFFSET_BITS-1:0] acc_q, acc_n;
	logic                   begin_seen_q, begin_seen_n;
	logic                   collecting_q, collecting_n;
	logic [7:0]             segs_q, segs_n;

	logic [OFFSET_BITS-1:0] ofs_inc;
	logic [OFFSET_BITS-1:0] hdr_pos;
	logic [OFFSET_BITS-1:0] size;
	logic [7:0]             segs_dec;
	logic                   finish;
	logic                   too_small;
	logic                   emit;

	function automatic logic [OFFSET_BITS-1:0] sat_add(
		input logic [OFFSET_BITS-1:0] a,
		input logic [8:0]             b
	);
		logic [OFFSET_BITS:0] s;
		s = {1'b0, a} + (OFFSET_BITS+1)'(b);
		return s[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : s[OFFSET_BITS-1:0];
	endfunction

	assign ofs_inc  = sat_add(ofs_q, 9'd1);
	assign hdr_pos  = ofs_q - OFFSET_BITS'(WIN_LEN - 1);
	assign segs_dec = segs_q - {7'd0, (segs_q != 8'd0)};

	always_comb begin
		ofs_n        = ofs_q;
		begin_n      = begin_q;
		acc_n        = acc_q;
		begin_seen_n = begin_seen_q;
		collecting_n = collecting_q;
		segs_n       = segs_q;
		finish       = 1'b0;

		if (collecting_q) begin
			// header matches inside a segment table are ignored
			acc_n  = sat_add(acc_q, {1'b0, data_byte});
			segs_n = segs_dec;
			finish = (segs_dec == 8'd0);
		end else if (info.sig_match) begin
			case (info.hdr_type)
				TYPE_BOS: begin
					begin_seen_n = 1'b1;
					begin_n      = hdr_pos;
				end
				TYPE_EOS, TYPE_EOS_CONT: begin
					if (begin_seen_q) begin
						// data_byte is the segment count here
						acc_n = sat_add(ofs_q, 9'd1 + {1'b0, data_byte});
						if (data_byte == 8'd0) begin
							finish = 1'b1;
						end else begin
							collecting_n = 1'b1;
							segs_n       = data_byte;
						end
					end
				end
				default: ;
			endcase
		end

		size      = (acc_n >= begin_q) ? (acc_n - begin_q) : '0;
		too_small = (min_size_kib != '0) &&
			(CMP_W'(size) < CMP_W'({min_size_kib, {KIB_SHIFT{1'b0}}}));
		emit      = finish && !too_small;

		if (finish) begin
			begin_seen_n = 1'b0;
			collecting_n = 1'b0;
			segs_n       = 8'd0;
		end

		res.valid     = emit;
		res.kind      = KIND_STREAM;
		res.start_ofs = RESULT_W'(begin_q);
		res.end_ofs   = RESULT_W'(acc_n);

		if (eoc) begin
			if (!emit && (collecting_n || info.tail_sync)) begin
				res.valid     = 1'b1;
				res.kind      = KIND_TRUNC;
				res.start_ofs = begin_seen_n ? RESULT_W'(begin_n) : '0;
				res.end_ofs   = RESULT_W'(ofs_inc);
			end
			ofs_n        = '0;
			begin_n      = '0;
			acc_n        = '0;
			begin_seen_n = 1'b0;
			collecting_n = 1'b0;
			segs_n       = 8'd0;
		end else begin
			ofs_n = ofs_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q        <= '0;
			begin_q      <= '0;
			acc_q        <= '0;
			begin_seen_q <= 1'b0;
			collecting_q <= 1'b0;
			segs_q       <= 8'd0;
		end else if (step) begin
			ofs_q        <= ofs_n;
			begin_q      <= begin_n;
			acc_q        <= acc_n;
			begin_seen_q <= begin_seen_n;
			collecting_q <= collecting_n;
			segs_q       <= segs_n;
		end
	end

	assign status.collecting   = collecting_q;
	assign status.segs_nonzero = (segs_q != 8'd0);
	assign status.begin_seen   = begin_seen_q;

endmodule

`default_nettype wire

### src/ogg_stream_boundary_scanner_top.sv
// Top level of the Ogg stream boundary scanner: handshakes, registers, checks.
//
// Feed the container one byte per beat, end_of_container set on its last byte.
// The scanner keeps a 27-byte window and the byte offset; a page header with
// "OggS" and type 0x02 marks a stream start, a later header of type 0x04 or 0x05
// gives the end (header offset + 27 + segment count + sum of segment sizes,
// sizes unsigned). A stream shorter than min_size_kib KiB is dropped (0 keeps
// all). A header or segment table cut off by the end of the container yields a
// result with result_kind = 1, stream_start = recorded start (or 0) and
// stream_end = container length. Offsets saturate at 2^OFFSET_BITS - 1; the
// scan state clears after each container, min_size_kib stays.
// Rate: one byte per clock sustained, unless a result waits with out_ready low.
// A byte goes into the input register on accept; all of its work happens in one
// pass through window and tracker once the output register can take its result,
// and its result (if any) sits in the output register from then on, holding
// out_valid until the result beat completes. While a result waits, one more byte
// can be taken into the input register; then in_ready stays low until the result
// beat completes. No clearing pass after reset.
// min_size_kib is written through the cfg beat and should change only while
// the scanner is idle.
`default_nettype none

module ogg_stream_boundary_scanner_top #(
	parameter int unsigned OFFSET_BITS = ogg_sbs_pkg::DEF_OFFSET_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ogg_sbs_pkg::MIN_KIB_W-1:0] min_size_kib,
	// byte input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              end_of_container,
	// results
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              result_kind,
	output logic [ogg_sbs_pkg::RESULT_W-1:0]  stream_start,
	output logic [ogg_sbs_pkg::RESULT_W-1:0]  stream_end
);
	import ogg_sbs_pkg::*;

	logic [MIN_KIB_W-1:0] min_size_q;

	logic                 valid_s1;
	logic [7:0]           data_byte_s1;
	logic                 eoc_s1;

	logic                 valid_s2;
	logic                 result_kind_s2;
	logic [RESULT_W-1:0]  stream_start_s2;
	logic [RESULT_W-1:0]  stream_end_s2;

	logic                 fire;
	win_info_t            win_info;
	trk_result_t          trk_res;
	trk_status_t          trk_status;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q <= '0;
		end else if (cfg_valid) begin
			min_size_q <= min_size_kib;
		end
	end

	// stage 1 byte is processed when the output register can take its result
	assign fire     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_byte_s1 <= data_byte;
			eoc_s1       <= end_of_container;
		end
	end

	ogg_sbs_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (fire),
		.clear     (eoc_s1),
		.data_byte (data_byte_s1),
		.info      (win_info)
	);

	ogg_sbs_tracker #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (fire),
		.data_byte    (data_byte_s1),
		.eoc          (eoc_s1),
		.min_size_kib (min_size_q),
		.info         (win_info),
		.res          (trk_res),
		.status       (trk_status)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && trk_res.valid) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && trk_res.valid) begin
			result_kind_s2  <= trk_res.kind;
			stream_start_s2 <= trk_res.start_ofs;
			stream_end_s2   <= trk_res.end_ofs;
		end
	end

	assign out_valid    = valid_s2;
	assign result_kind  = result_kind_s2;
	assign stream_start = stream_start_s2;
	assign stream_end   = stream_end_s2;

	// collecting a segment table always has segments left to take
	a_collect_has_segs: assert property (@(posedge clk) disable iff (!arst_n)
		trk_status.collecting == trk_status.segs_nonzero)
		else $error("segment count out of step with collecting flag");

	// last byte of a container leaves the scan cleared
	a_eoc_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoc_s1 |=> !trk_status.begin_seen && !trk_status.collecting)
		else $error("scan state not cleared after end of container");

	// a found stream never ends before it starts
	a_end_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (result_kind_s2 == KIND_STREAM) && (OFFSET_BITS <= RESULT_W)
		|-> stream_end_s2 > stream_start_s2)
		else $error("stream end not past stream start");

	// nothing is processed while a held result blocks the output
	a_no_fire_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |-> !fire)
		else $error("byte processed while result stalled");

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the Ogg stream boundary scanner.
`timescale 1ns / 100ps

module testbench;
	import ogg_sbs_pkg::*;

	localparam int unsigned OFS_BITS    = DEF_OFFSET_BITS;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned QUIET_CYCLES = 8;   // result latency is short, leave margin
	localparam int unsigned HOLD_CYCLES = 400;  // long receiver hold-off

	typedef struct packed {
		logic                kind;
		logic [RESULT_W-1:0] start_ofs;
		logic [RESULT_W-1:0] end_ofs;
	} boundary_t;

	// pacing of the two channels
	typedef enum {PACE_FULL, PACE_SEND_SPARSE, PACE_RECV_SPARSE, PACE_BOTH} pace_t;

	// container layouts used by the generator
	typedef enum {
		SHAPE_MIXED,         // random mix of noise, start and end pages
		SHAPE_EMPTY_TABLE,   // end page with zero segments
		SHAPE_RESTART,       // second start page replaces the first
		SHAPE_HDR_IN_TABLE,  // fake header bytes inside a segment table
		SHAPE_CUT_TABLE,     // container ends inside a segment table
		SHAPE_CUT_HEADER,    // container ends inside a page header
		SHAPE_STREAM_AT_EOC, // stream closes on the last byte, O in the tail
		SHAPE_ORPHAN_END,    // end page with no start before it
		SHAPE_TABLE_AT_EOC   // last table byte is the last byte, O in the table
	} shape_t;

	// Predicts scanner output byte by byte and checks results in order.
	class boundary_tracker_t;
		logic [7:0]  page_win [WIN_LEN];
		bit   [63:0] next_ofs;
		bit   [63:0] start_ofs;
		bit   [63:0] end_ofs;
		bit          start_known;
		bit          in_table;
		bit   [7:0]  table_left;
		bit   [MIN_KIB_W-1:0] floor_kib;
		boundary_t   due [$];
		int unsigned errors;
		int unsigned streams;
		int unsigned truncs;
		int unsigned dropped;

		function new();
			floor_kib = '0;
			clear_scan();
		endfunction

		function void clear_scan();
			foreach (page_win[i])
				page_win[i] = 8'h00;
			next_ofs    = 0;
			start_known = 1'b0;
			start_ofs   = 0;
			in_table    = 1'b0;
			table_left  = 0;
			end_ofs     = 0;
		endfunction

		function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
			bit [63:0] lim;
			bit [63:0] s;
			lim = (64'd1 << OFS_BITS) - 64'd1;
			s   = a + b;
			if (s < a || s > lim)
				return lim;
			return s;
		endfunction

		function void set_floor(bit [MIN_KIB_W-1:0] kib);
			floor_kib = kib;
		endfunction

		function int unsigned pending();
			return due.size();
		endfunction

		function void push_due(logic kind, bit [63:0] s, bit [63:0] e);
			boundary_t r;
			r.kind      = kind;
			r.start_ofs = s[RESULT_W-1:0];
			r.end_ofs   = e[RESULT_W-1:0];
			due = {due, r};
		endfunction

		// stream complete: emit unless below the size floor
		function bit close_stream();
			bit [63:0] size;
			bit [63:0] floor_bytes;
			bit        emit;
			size        = (end_ofs >= start_ofs) ? end_ofs - start_ofs : 64'd0;
			floor_bytes = 64'(floor_kib) << KIB_SHIFT;
			emit        = !(floor_kib != 0 && size < floor_bytes);
			if (emit)
				push_due(KIND_STREAM, start_ofs, end_ofs);
			else
				dropped++;
			start_known = 1'b0;
			in_table    = 1'b0;
			table_left  = 0;
			return emit;
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			bit [63:0] cur;
			bit [63:0] cnt;
			bit [63:0] span;
			bit [7:0]  nseg;
			bit        have;
			bit        err;
			cur  = next_ofs;
			have = 1'b0;
			for (int i = 0; i < WIN_LEN - 1; i++)
				page_win[i] = page_win[i + 1];
			page_win[WIN_LEN - 1] = b;

			if (in_table) begin
				end_ofs = sat_add(end_ofs, 64'(b));
				if (table_left != 0)
					table_left--;
				if (table_left == 0)
					have = close_stream();
			end else if (cur >= WIN_LEN - 1 && page_win[0] == SYNC_O &&
			             page_win[1] == SYNC_G && page_win[2] == SYNC_G &&
			             page_win[3] == SYNC_S) begin
				if (page_win[5] == TYPE_BOS) begin
					start_known = 1'b1;
					start_ofs   = cur - (WIN_LEN - 1);
				end else if (start_known && (page_win[5] == TYPE_EOS ||
				                             page_win[5] == TYPE_EOS_CONT)) begin
					nseg    = page_win[WIN_LEN - 1];
					end_ofs = sat_add(cur, 64'd1 + 64'(nseg));
					if (nseg == 0) begin
						have = close_stream();
					end else begin
						in_table   = 1'b1;
						table_left = nseg;
					end
				end
			end

			if (last) begin
				if (!have) begin
					err = in_table;
					cnt = sat_add(cur, 1);
					span = (cnt < WIN_LEN - 1) ? cnt : 64'(WIN_LEN - 1);
					for (int i = 0; i < span; i++)
						if (page_win[WIN_LEN - 1 - i] == SYNC_O)
							err = 1'b1;
					if (err)
						push_due(KIND_TRUNC, start_known ? start_ofs : 64'd0, cnt);
				end
				clear_scan();
			end else begin
				next_ofs = sat_add(cur, 1);
			end
		endfunction

		function void check_boundary(logic kind, logic [RESULT_W-1:0] s,
		                             logic [RESULT_W-1:0] e);
			boundary_t x;
			if (due.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: result with none expected: %s %0d start %0d end %0d",
					         $time, "kind", kind, s, e);
				errors++;
				return;
			end
			x = due.pop_front();
			if (x.kind !== kind || x.start_ofs !== s || x.end_ofs !== e) begin
				if (errors < MAX_REPORTS) begin
					$display("%0t: bad result: expected kind %0d start %0d end %0d,",
					         $time, x.kind, x.start_ofs, x.end_ofs);
					$display("    got kind %0d start %0d end %0d", kind, s, e);
				end
				errors++;
			end else if (kind == KIND_STREAM) begin
				streams++;
			end else begin
				truncs++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [MIN_KIB_W-1:0] min_size_kib = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           data_byte = 8'h00;
	logic                 end_of_container = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 result_kind;
	logic [RESULT_W-1:0]  stream_start;
	logic [RESULT_W-1:0]  stream_end;

	boundary_tracker_t tracker;
	pace_t           pace_mode = PACE_FULL;
	int unsigned     hold_asked = 0;     // bumped by stimulus, served by the receiver
	int unsigned     cycle_count = 0;
	int unsigned     bytes_sent = 0;
	int unsigned     containers_sent = 0;
	logic [7:0]      pkt [$];            // container under construction

	ogg_stream_boundary_scanner_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.min_size_kib     (min_size_kib),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.end_of_container (end_of_container),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_kind      (result_kind),
		.stream_start     (stream_start),
		.stream_end       (stream_end)
	);

	initial begin
		forever begin
			#2 clk = ~clk;
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
		         cycle_count, tracker.pending());
		$display("end of test: mismatches");
		$finish;
	end

	// Result side: sample at the edge, then pick out_ready for the next cycle.
	// A hold-off request from the stimulus freezes out_ready for HOLD_CYCLES so
	// the output register fills and the scanner backs up into its input.
	initial begin : result_sink
		int unsigned hold_seen;
		int unsigned hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.check_boundary(result_kind, stream_start, stream_end);
			if (hold_asked != hold_seen) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (pace_mode)
					PACE_RECV_SPARSE: out_ready <= ($urandom_range(99) >= 85);
					PACE_BOTH:        out_ready <= ($urandom_range(99) >= 25);
					default:          out_ready <= 1'b1;
				endcase
			end
		end
	end

	// One byte beat; random idle cycles first depending on the pace.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned idle_pct;
		idle_pct = (pace_mode == PACE_SEND_SPARSE) ? 85 : (pace_mode == PACE_BOTH) ? 25 : 0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		data_byte        <= b;
		end_of_container <= last;
		do @(posedge clk); while (!in_ready);
		tracker.take_byte(b, last);
		bytes_sent++;
	endtask

	// Drop valid and wait until every predicted result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	// Whole container; optionally pause before byte pause_at until drained.
	task automatic send_container(input int pause_at);
		for (int i = 0; i < pkt.size(); i++) begin
			if (i == pause_at)
				drain();
			send_byte(pkt[i], i == pkt.size() - 1);
		end
		containers_sent++;
	endtask

	// Idle the scanner, then set the pace and write the size floor.
	task automatic start_phase(input pace_t pace, input logic [MIN_KIB_W-1:0] kib);
		drain();
		repeat (QUIET_CYCLES) @(posedge clk);
		pace_mode    <= pace;
		cfg_valid    <= 1'b1;
		min_size_kib <= kib;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.set_floor(kib);
	endtask

	// add one byte at the tail of the container under construction
	function automatic void append_byte(input logic [7:0] b);
		pkt = {pkt, b};
	endfunction

	task automatic add_noise(input int unsigned n);
		repeat (n)
			append_byte(($urandom_range(15) == 0) ? SYNC_O : 8'($urandom));
	endtask

	// 27-byte page header; o_in_field plants a capital O among the random fields.
	task automatic add_header(input logic [7:0] kind, input logic [7:0] nseg,
	                          input bit o_in_field);
		append_byte(SYNC_O);
		append_byte(SYNC_G);
		append_byte(SYNC_G);
		append_byte(SYNC_S);
		append_byte(8'h00);
		append_byte(kind);
		repeat (20)
			append_byte(8'($urandom));
		if (o_in_field)
			pkt[pkt.size() - 1 - $urandom_range(19, 0)] = SYNC_O;
		append_byte(nseg);
	endtask

	// Segment table; lacing values of 255 are common, fake_hdr hides a start page.
	task automatic add_table(input int unsigned n, input bit fake_hdr);
		int unsigned at;
		repeat (n)
			append_byte(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));
		if (fake_hdr && n >= 6) begin
			at = pkt.size() - n + $urandom_range(n - 6, 0);
			pkt[at]     = SYNC_O;
			pkt[at + 1] = SYNC_G;
			pkt[at + 2] = SYNC_G;
			pkt[at + 3] = SYNC_S;
			pkt[at + 4] = 8'h00;
			pkt[at + 5] = TYPE_BOS;
		end
	endtask

	function automatic logic [7:0] pick_nseg();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'($urandom_range(255, 100));
		if (r == 1)
			return 8'd0;
		return 8'($urandom_range(12, 1));
	endfunction

	function automatic logic [7:0] end_type();
		return $urandom_range(1) ? TYPE_EOS : TYPE_EOS_CONT;
	endfunction

	task automatic add_start_page();
		int unsigned n;
		n = $urandom_range(3, 0);
		add_header(TYPE_BOS, 8'(n), 1'b0);
		add_table(n, 1'b0);
	endtask

	task automatic add_end_page(input logic [7:0] kind, input bit fake_hdr);
		logic [7:0] n;
		n = pick_nseg();
		add_header(kind, n, 1'b0);
		add_table(n, fake_hdr);
	endtask

	task automatic build_container(input shape_t shape);
		int unsigned n;
		int unsigned r;
		pkt.delete();
		add_noise($urandom_range(6, 0));
		case (shape)
			SHAPE_MIXED: begin
				repeat ($urandom_range(4, 1)) begin
					r = $urandom_range(9);
					if (r < 3)
						add_noise($urandom_range(10, 0));
					else if (r < 6)
						add_start_page();
					else if (r < 9)
						add_end_page(end_type(), $urandom_range(7) == 0);
					else
						add_end_page(8'($urandom), 1'b0);
				end
				add_noise($urandom_range(4, 0));
				// sometimes cut the tail short
				if (pkt.size() > 1 && $urandom_range(4) == 0) begin
					n = (pkt.size() - 1 < 30) ? pkt.size() - 1 : 30;
					repeat ($urandom_range(n, 1))
						void'(pkt.pop_back());
				end
			end
			SHAPE_EMPTY_TABLE: begin
				add_start_page();
				add_header(end_type(), 8'd0, 1'b0);
				add_noise($urandom_range(5, 0));
			end
			SHAPE_RESTART: begin
				add_start_page();
				add_noise($urandom_range(8, 0));
				add_start_page();
				add_end_page(end_type(), 1'b0);
			end
			SHAPE_HDR_IN_TABLE: begin
				add_start_page();
				n = $urandom_range(40, 8);
				add_header(end_type(), 8'(n), 1'b0);
				add_table(n, 1'b1);
				add_noise($urandom_range(30, 0));
			end
			SHAPE_CUT_TABLE: begin
				add_start_page();
				n = $urandom_range(40, 4);
				add_header(end_type(), 8'(n), 1'b0);
				add_table($urandom_range(n - 1, 0), 1'b0);
			end
			SHAPE_CUT_HEADER: begin
				add_start_page();
				add_header(end_type(), pick_nseg(), 1'b0);
				repeat ($urandom_range(23, 1))
					void'(pkt.pop_back());
			end
			SHAPE_STREAM_AT_EOC: begin
				add_start_page();
				add_header(end_type(), 8'd0, 1'b1);
			end
			SHAPE_ORPHAN_END: begin
				add_end_page(end_type(), 1'b0);
				add_noise($urandom_range(8, 0));
			end
			default: begin // SHAPE_TABLE_AT_EOC
				add_start_page();
				n = $urandom_range(20, 2);
				add_header(end_type(), 8'(n), 1'b0);
				add_table(n, 1'b0);
				pkt[pkt.size() - 1 - $urandom_range(n - 1, 0)] = SYNC_O;
			end
		endcase
		if (pkt.size() == 0)
			append_byte(8'($urandom));
	endtask

	// Mostly mixed containers, the rest picked at random from the corner layouts.
	task automatic random_containers(input int unsigned budget);
		int unsigned target;
		target = bytes_sent + budget;
		while (bytes_sent < target) begin
			if ($urandom_range(9) < 6)
				build_container(SHAPE_MIXED);
			else
				build_container(shape_t'($urandom_range(SHAPE_TABLE_AT_EOC,
				                                        SHAPE_EMPTY_TABLE)));
			send_container(-1);
		end
	endtask

	initial begin : stimulus
		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte extremes, single-byte containers, header cut short.
		start_phase(PACE_FULL, 16'd0);
		pkt = '{8'h00};
		send_container(-1);
		pkt = '{8'hFF};
		send_container(-1);
		pkt = '{8'h80};
		send_container(-1);
		pkt = '{SYNC_O};
		send_container(-1);
		pkt = '{SYNC_O, 8'h00, 8'hFF};
		send_container(-1);
		pkt = '{8'h12, SYNC_O, SYNC_G, SYNC_G, SYNC_S, 8'h00, TYPE_BOS};
		send_container(-1);

		// every corner layout once, random content
		for (int s = SHAPE_EMPTY_TABLE; s <= SHAPE_TABLE_AT_EOC; s++) begin
			build_container(shape_t'(s));
			send_container(-1);
		end
		random_containers(100);

		start_phase(PACE_SEND_SPARSE, 16'd0);
		random_containers(120);

		// sparse receiver; the sender also stops mid-container until drained
		start_phase(PACE_RECV_SPARSE, 16'd1);
		random_containers(60);
		build_container(SHAPE_HDR_IN_TABLE);
		send_container(30);
		random_containers(60);

		start_phase(PACE_BOTH, 16'd30);
		random_containers(120);

		start_phase(PACE_FULL, 16'hFFFF);
		random_containers(80);

		// Back-pressure: receiver holds off while one-byte containers, each a
		// truncation, keep arriving at full rate.
		start_phase(PACE_FULL, 16'd0);
		hold_asked <= hold_asked + 1;
		repeat (40) begin
			pkt = '{SYNC_O};
			send_container(-1);
		end
		random_containers(60);

		start_phase(PACE_BOTH, 16'd2);
		random_containers(80);

		drain();
		repeat (QUIET_CYCLES) @(posedge clk);
		$display("covered %0d bytes in %0d containers over seven pacing/floor settings",
		         bytes_sent, containers_sent);
		$display("checked %0d streams and %0d truncations, %0d streams under the floor, %0d bad",
		         tracker.streams, tracker.truncs, tracker.dropped, tracker.errors);
		if (tracker.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
